// File: src/hbm_pkg.sv
// Shared types and constants for the heartbeat membership table.
// Holds the op, action and register index codes, the per-item beat carried
// down the cell chain, and the context the top level broadcasts to every cell.
package hbm_pkg;

	localparam int unsigned HBM_ENTRIES_DEF = 64;

	localparam int unsigned ID_W   = 6;
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned HB_W   = 32;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TO_W   = 16;
	localparam int unsigned PER_W  = 8;
	localparam int unsigned CNT_W  = 7;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_JOIN   = 2'd1,
		OP_REPLY  = 2'd2,
		OP_GOSSIP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_IGNORED = 3'd0,
		ACT_ADDED   = 3'd1,
		ACT_UPDATED = 3'd2,
		ACT_KEPT    = 3'd3,
		ACT_TICK    = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		REG_FAIL     = 3'd0,
		REG_CLEANUP  = 3'd1,
		REG_PERIOD   = 3'd2,
		REG_SELF     = 3'd3,
		REG_START    = 3'd4,
		REG_INIT_HB  = 3'd5
	} reg_idx_t;

	// One item traveling down the chain, with the result built on the way.
	typedef struct packed {
		logic              active;
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [ADDR_W-1:0] addr;
		logic [HB_W-1:0]   hb;
		logic              last;
		action_t           act;
		logic [CNT_W-1:0]  cnt;
	} link_t;

	// Values that stay put while an item is in the chain, provided config writes keep to idle periods.
	typedef struct packed {
		logic              in_group;
		logic              round;
		logic [TIME_W-1:0] now;
		logic [TO_W-1:0]   fail;
		logic [TO_W:0]     limit;
		logic [HB_W-1:0]   init_hb;
		logic [ID_W-1:0]   self_id;
	} ctx_t;

endpackage

// File: src/hbm_cell.sv
// One table slot of the heartbeat membership table.
// Depends on hbm_pkg for the chain beat and the broadcast context.
// Acts on the beat passing through, then hands it to the next cell.
module hbm_cell
	import hbm_pkg::*;
#(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  ctx_t  ctx,
	input  link_t in_link,
	output link_t out_link
);

	logic              valid_q;
	logic              removed_q;
	logic [ADDR_W-1:0] addr_q;
	logic [HB_W-1:0]   hb_q;
	logic [TIME_W-1:0] stamp_q;
	link_t             link_q;

	link_t             nxt;
	logic              hit;
	logic              self_hit;
	logic [TIME_W-1:0] age;
	logic [HB_W-1:0]   hb_inc;
	logic              do_write;
	logic [HB_W-1:0]   wr_hb;
	logic              do_upd;
	logic              do_remove;
	logic              do_bump;

	assign hit      = (32'(in_link.id) == CELL_IDX);
	assign self_hit = (32'(ctx.self_id) == CELL_IDX);
	assign age      = ctx.now - stamp_q;
	assign hb_inc   = (hb_q == '1) ? hb_q : hb_q + HB_W'(1);

	always_comb begin
		nxt       = in_link;
		do_write  = 1'b0;
		wr_hb     = in_link.hb;
		do_upd    = 1'b0;
		do_remove = 1'b0;
		do_bump   = 1'b0;
		if (in_link.active) begin
			case (in_link.op)
				OP_TICK: begin
					if (ctx.in_group) begin
						do_remove = valid_q && !removed_q && (age > TIME_W'(ctx.limit));
						do_bump   = ctx.round && self_hit && valid_q;
					end
					if (do_remove && in_link.cnt != '1)
						nxt.cnt = in_link.cnt + CNT_W'(1);
				end
				OP_REPLY: begin
					if (hit) begin
						do_write = 1'b1;
						nxt.act  = valid_q ? ACT_UPDATED : ACT_ADDED;
					end
				end
				OP_JOIN: begin
					if (hit && ctx.in_group) begin
						do_write = 1'b1;
						wr_hb    = ctx.init_hb;
						nxt.act  = valid_q ? ACT_UPDATED : ACT_ADDED;
					end
				end
				default: begin
					if (hit && ctx.in_group) begin
						if (!valid_q) begin
							do_write = 1'b1;
							nxt.act  = ACT_ADDED;
						end else if (in_link.hb > hb_q && age <= TIME_W'(ctx.fail)) begin
							do_upd  = 1'b1;
							nxt.act = ACT_UPDATED;
						end else begin
							nxt.act = ACT_KEPT;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			removed_q <= 1'b0;
			link_q    <= '0;
		end else if (adv) begin
			link_q <= nxt;
			if (do_write) begin
				valid_q   <= 1'b1;
				removed_q <= 1'b0;
			end else if (do_remove) begin
				removed_q <= 1'b1;
			end
		end
	end

	// Slot payload carries no reset.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (do_write) begin
				addr_q  <= in_link.addr;
				hb_q    <= wr_hb;
				stamp_q <= ctx.now;
			end else if (do_upd) begin
				hb_q    <= in_link.hb;
				stamp_q <= ctx.now;
			end else if (do_bump) begin
				hb_q    <= hb_inc;
				stamp_q <= ctx.now;
			end
		end
	end

	assign out_link = link_q;

endmodule

// File: src/heartbeat_membership_table.sv
// Heartbeat membership table: gossip heartbeat failure detector.
// Depends on hbm_pkg and hbm_cell; one cell per table slot.
//
// Usage: items enter on in_valid/in_ready (op, entry_id, entry_addr,
// heartbeat_value, last_of_message) and each gives one result beat on
// out_valid/out_ready (action, removed_now, gossip_due, in_group_now).
// Registers are written on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, and writes belong to idle periods.
// An item is captured in a head register and then walks the row of
// TABLE_ENTRIES cells, one cell per cycle unless the row is frozen, and
// then enters the output register. One item is in the row at a time:
// a new item is taken the cycle after the previous one reaches the output
// register. The next item may enter while a result waits.
// If the receiver stalls with a result held and another item reaches the
// end of the row, the whole row freezes until the held beat is taken.
// Reset clears all slot valid and removed marks, time, the gossip
// countdown and the in-group flag, and loads register defaults; no
// clearing pass is needed.
module heartbeat_membership_table
	import hbm_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = HBM_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [ID_W-1:0]   entry_id,
	input  logic [ADDR_W-1:0] entry_addr,
	input  logic [HB_W-1:0]   heartbeat_value,
	input  logic              last_of_message,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        action,
	output logic [CNT_W-1:0]  removed_now,
	output logic              gossip_due,
	output logic              in_group_now
);

	logic [TO_W-1:0]   fail_q;
	logic [TO_W-1:0]   cleanup_q;
	logic [PER_W-1:0]  period_q;
	logic [ID_W-1:0]   self_id_q;
	logic [HB_W-1:0]   init_hb_q;
	logic              in_group_q;
	logic [TIME_W-1:0] now_q;
	logic [PER_W-1:0]  countdown_q;
	logic              busy_q;
	link_t             head_q;

	logic              out_valid_q;
	action_t           action_q;
	logic [CNT_W-1:0]  removed_q;
	logic              gossip_due_q;
	logic              in_group_now_q;

	link_t             chain [TABLE_ENTRIES+1];
	link_t             tail;
	ctx_t              ctx;
	logic              adv;
	logic              finish;
	logic              accept;
	logic              cfg_we;
	logic              round;
	logic              in_group_nxt;
	logic [PER_W-1:0]  reload;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;
	assign in_ready  = !busy_q;
	assign accept    = in_valid && !busy_q;

	assign tail   = chain[TABLE_ENTRIES];
	// Freeze the row while a finished item cannot move into the output stage.
	assign adv    = !(tail.active && out_valid_q && !out_ready);
	assign finish = tail.active && adv;

	assign round  = (countdown_q == '0);
	assign reload = (period_q == '0) ? '0 : period_q - PER_W'(1);

	assign ctx.in_group = in_group_q;
	assign ctx.round    = round;
	assign ctx.now      = now_q;
	assign ctx.fail     = fail_q;
	assign ctx.limit    = {1'b0, fail_q} + {1'b0, cleanup_q};
	assign ctx.init_hb  = init_hb_q;
	assign ctx.self_id  = self_id_q;

	assign in_group_nxt = in_group_q || (tail.op == OP_REPLY && tail.last);

	assign chain[0] = head_q;

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		hbm_cell #(
			.CELL_IDX (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctx      (ctx),
			.in_link  (chain[g]),
			.out_link (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q        <= TO_W'(5);
			cleanup_q     <= TO_W'(20);
			period_q      <= PER_W'(4);
			self_id_q     <= '0;
			init_hb_q     <= '0;
			in_group_q    <= 1'b0;
			now_q         <= '0;
			countdown_q   <= '0;
			busy_q        <= 1'b0;
			head_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_FAIL:    fail_q     <= cfg_data[TO_W-1:0];
					REG_CLEANUP: cleanup_q  <= cfg_data[TO_W-1:0];
					REG_PERIOD:  period_q   <= cfg_data[PER_W-1:0];
					REG_SELF:    self_id_q  <= cfg_data[ID_W-1:0];
					REG_START:   in_group_q <= cfg_data[0];
					REG_INIT_HB: init_hb_q  <= cfg_data[HB_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				head_q.active <= 1'b1;
				head_q.op     <= op_t'(op);
				head_q.id     <= entry_id;
				head_q.addr   <= entry_addr;
				head_q.hb     <= heartbeat_value;
				head_q.last   <= last_of_message;
				head_q.act    <= (op_t'(op) == OP_TICK) ? ACT_TICK : ACT_IGNORED;
				head_q.cnt    <= '0;
				busy_q        <= 1'b1;
			end else if (adv) begin
				head_q.active <= 1'b0;
			end

			if (finish) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				if (tail.op == OP_TICK) begin
					countdown_q <= round ? reload : countdown_q - PER_W'(1);
					now_q       <= now_q + TIME_W'(1);
				end
				in_group_q <= in_group_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (finish) begin
			action_q       <= tail.act;
			removed_q      <= tail.cnt;
			gossip_due_q   <= (tail.op == OP_TICK) && round && in_group_q;
			in_group_now_q <= in_group_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign removed_now  = removed_q;
	assign gossip_due   = gossip_due_q;
	assign in_group_now = in_group_now_q;

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !head_q.active && !tail.active)
		else $error("item in cell row while block is idle");

	a_tail_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> busy_q)
		else $error("item left the row without an owner");

	a_entry_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && action_q != ACT_TICK |-> removed_q == '0 && !gossip_due_q)
		else $error("tick fields set on an entry result");

	a_gossip_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && gossip_due_q |-> in_group_now_q)
		else $error("gossip round reported outside the group");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q && !busy_q)
		else $error("finished item did not reach the output stage");

endmodule
